// File: rtl/mptw_pkg.sv
// Package: shared widths, codes, microcode control word and the walker's microprogram.
`default_nettype none

package mptw_pkg;

  // Default sizing of the frame memory and of the walk
  localparam int unsigned NUM_FRAMES_DEF = 64;
  localparam int unsigned LEVELS_DEF     = 5;
  localparam int unsigned INDEX_BITS_DEF = 9;
  localparam int unsigned PPN_BITS_DEF   = 52;

  // Fixed field widths of the ports
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned VP_W       = 45;
  localparam int unsigned PP_W       = 52;
  localparam int unsigned ROOT_W     = 6;
  localparam int unsigned FFREE_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_UNMAP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MAPPING = 2'd1,
    ST_NO_FRAMES  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_FRAME = 1'd0,
    CFG_FIRST_FREE = 1'd1
  } cfg_idx_e;

  // Datapath operation of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LOAD,
    ACT_DESCEND,
    ACT_ALLOC,
    ACT_MAP_WR,
    ACT_UNMAP_WR,
    ACT_Q_MISS,
    ACT_Q_HIT,
    ACT_NOFRAME,
    ACT_PUSH
  } act_e;

  // Jump condition of one microcode step
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CLR_BUSY,
    COND_NO_REQ,
    COND_IS_QUERY,
    COND_LAST,
    COND_ENTRY_ZERO,
    COND_NO_FRAME,
    COND_IS_UNMAP,
    COND_ENTRY_INVALID,
    COND_OUT_BLOCKED
  } cond_e;

  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic  rd_en;
    logic  ready;
    act_e  act;
    cond_e cond;
    step_t target;
  } ctrl_t;

  // Status flags from the datapath for jump decisions
  typedef struct packed {
    logic clr_busy;
    logic req_valid;
    logic is_query;
    logic is_unmap;
    logic last;
    logic entry_zero;
    logic entry_valid;
    logic no_frame;
    logic out_blocked;
  } seq_flags_t;

  // Microprogram addresses
  localparam step_t STEP_CLR      = 5'd0;
  localparam step_t STEP_IDLE     = 5'd1;
  localparam step_t STEP_DISP     = 5'd2;
  localparam step_t STEP_M_RD     = 5'd3;
  localparam step_t STEP_M_LAST   = 5'd4;
  localparam step_t STEP_M_ZERO   = 5'd5;
  localparam step_t STEP_M_DESC   = 5'd6;
  localparam step_t STEP_M_AVAIL  = 5'd7;
  localparam step_t STEP_M_ALLOC  = 5'd8;
  localparam step_t STEP_LEAF     = 5'd9;
  localparam step_t STEP_MAP_WR   = 5'd10;
  localparam step_t STEP_UNMAP_WR = 5'd11;
  localparam step_t STEP_Q_RD     = 5'd12;
  localparam step_t STEP_Q_VALID  = 5'd13;
  localparam step_t STEP_Q_LAST   = 5'd14;
  localparam step_t STEP_Q_DESC   = 5'd15;
  localparam step_t STEP_Q_MISS   = 5'd16;
  localparam step_t STEP_Q_HIT    = 5'd17;
  localparam step_t STEP_NOFRAME  = 5'd18;
  localparam step_t STEP_RESP     = 5'd19;
  localparam step_t STEP_RET      = 5'd20;

  function automatic ctrl_t uc(logic rd, logic rdy, act_e a, cond_e c, step_t t);
    ctrl_t w;
    w.rd_en  = rd;
    w.ready  = rdy;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Control store: one word per step, fall through to step + 1 when the jump is not taken
  function automatic ctrl_t ucode_rom(step_t step);
    ctrl_t w;
    case (step)
      STEP_CLR:      w = uc(1'b0, 1'b0, ACT_CLEAR,    COND_CLR_BUSY,      STEP_CLR);
      STEP_IDLE:     w = uc(1'b0, 1'b1, ACT_LOAD,     COND_NO_REQ,        STEP_IDLE);
      STEP_DISP:     w = uc(1'b0, 1'b0, ACT_NONE,     COND_IS_QUERY,      STEP_Q_RD);
      STEP_M_RD:     w = uc(1'b1, 1'b0, ACT_NONE,     COND_NEVER,         STEP_M_RD);
      STEP_M_LAST:   w = uc(1'b0, 1'b0, ACT_NONE,     COND_LAST,          STEP_LEAF);
      STEP_M_ZERO:   w = uc(1'b0, 1'b0, ACT_NONE,     COND_ENTRY_ZERO,    STEP_M_AVAIL);
      STEP_M_DESC:   w = uc(1'b0, 1'b0, ACT_DESCEND,  COND_ALWAYS,        STEP_M_RD);
      STEP_M_AVAIL:  w = uc(1'b0, 1'b0, ACT_NONE,     COND_NO_FRAME,      STEP_NOFRAME);
      STEP_M_ALLOC:  w = uc(1'b0, 1'b0, ACT_ALLOC,    COND_ALWAYS,        STEP_M_RD);
      STEP_LEAF:     w = uc(1'b0, 1'b0, ACT_NONE,     COND_IS_UNMAP,      STEP_UNMAP_WR);
      STEP_MAP_WR:   w = uc(1'b0, 1'b0, ACT_MAP_WR,   COND_ALWAYS,        STEP_RESP);
      STEP_UNMAP_WR: w = uc(1'b0, 1'b0, ACT_UNMAP_WR, COND_ALWAYS,        STEP_RESP);
      STEP_Q_RD:     w = uc(1'b1, 1'b0, ACT_NONE,     COND_NEVER,         STEP_Q_RD);
      STEP_Q_VALID:  w = uc(1'b0, 1'b0, ACT_NONE,     COND_ENTRY_INVALID, STEP_Q_MISS);
      STEP_Q_LAST:   w = uc(1'b0, 1'b0, ACT_NONE,     COND_LAST,          STEP_Q_HIT);
      STEP_Q_DESC:   w = uc(1'b0, 1'b0, ACT_DESCEND,  COND_ALWAYS,        STEP_Q_RD);
      STEP_Q_MISS:   w = uc(1'b0, 1'b0, ACT_Q_MISS,   COND_ALWAYS,        STEP_RESP);
      STEP_Q_HIT:    w = uc(1'b0, 1'b0, ACT_Q_HIT,    COND_ALWAYS,        STEP_RESP);
      STEP_NOFRAME:  w = uc(1'b0, 1'b0, ACT_NOFRAME,  COND_ALWAYS,        STEP_RESP);
      STEP_RESP:     w = uc(1'b0, 1'b0, ACT_PUSH,     COND_OUT_BLOCKED,   STEP_RESP);
      STEP_RET:      w = uc(1'b0, 1'b0, ACT_NONE,     COND_ALWAYS,        STEP_IDLE);
      default:       w = uc(1'b0, 1'b0, ACT_NONE,     COND_ALWAYS,        STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mptw_ifs.sv
// Interfaces: request and response channels of the page table walker.
`default_nettype none

interface mptw_req_if
  import mptw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VP_W-1:0]   virtual_page;
  logic [PP_W-1:0]   physical_page;

  modport source (output valid, mode, virtual_page, physical_page, input ready);
  modport sink   (input valid, mode, virtual_page, physical_page, output ready);
endinterface

interface mptw_rsp_if
  import mptw_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PP_W-1:0] physical_page_out;
  logic            mapped;
  status_e         status;

  modport source (output valid, physical_page_out, mapped, status, input ready);
  modport sink   (input valid, physical_page_out, mapped, status, output ready);
endinterface

`default_nettype wire

// File: rtl/mptw_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module mptw_seq
  import mptw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire seq_flags_t flags_i,
  output ctrl_t           ctrl_o
);

  step_t upc_q, upc_d;
  ctrl_t ctrl;
  logic  take;

  // Fetch the control word of the current step
  assign ctrl   = ucode_rom(upc_q);
  assign ctrl_o = ctrl;

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:         take = 1'b0;
      COND_ALWAYS:        take = 1'b1;
      COND_CLR_BUSY:      take = flags_i.clr_busy;
      COND_NO_REQ:        take = !flags_i.req_valid;
      COND_IS_QUERY:      take = flags_i.is_query;
      COND_LAST:          take = flags_i.last;
      COND_ENTRY_ZERO:    take = flags_i.entry_zero;
      COND_NO_FRAME:      take = flags_i.no_frame;
      COND_IS_UNMAP:      take = flags_i.is_unmap;
      COND_ENTRY_INVALID: take = !flags_i.entry_valid;
      COND_OUT_BLOCKED:   take = flags_i.out_blocked;
      default:            take = 1'b0;
    endcase
    upc_d = take ? ctrl.target : upc_q + step_t'(1);
  end

  // Advance the step counter; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mptw_dp.sv
// Datapath: frame memory, walk registers, allocation counter and result register.
`default_nettype none

module mptw_dp
  import mptw_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned PPN_BITS   = PPN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire ctrl_t                 ctrl_i,
  output seq_flags_t                 flags_o,
  mptw_req_if.sink                   req,
  mptw_rsp_if.source                 rsp
);

  localparam int unsigned FRAME_W   = $clog2(NUM_FRAMES);
  localparam int unsigned ADDR_W    = FRAME_W + INDEX_BITS;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned ENT_W     = PPN_BITS + 1;
  localparam int unsigned NF_MIN    = $clog2(NUM_FRAMES + 1);
  localparam int unsigned NF_W      = (NF_MIN > FFREE_W) ? NF_MIN : FFREE_W;
  localparam int unsigned FR_W      = (PPN_BITS > NF_W) ? PPN_BITS : NF_W;
  localparam int unsigned LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned VA_W      = LEVELS * INDEX_BITS;

  logic [ENT_W-1:0]      mem [MEM_DEPTH];

  logic [ROOT_W-1:0]     root_q;
  logic [NF_W-1:0]       next_q;
  logic [ADDR_W-1:0]     clr_q;
  logic [MODE_W-1:0]     mode_q;
  logic [VA_W-1:0]       vp_q;
  logic [PPN_BITS-1:0]   pp_q;
  logic [FR_W-1:0]       frame_q;
  logic [LVL_W-1:0]      level_q;
  logic [ENT_W-1:0]      rdata_q;
  logic                  rd_oor_q;

  logic [PP_W-1:0]       res_pp_q;
  logic                  res_mapped_q;
  status_e               res_status_q;

  logic                  out_valid_q;
  logic [PP_W-1:0]       out_pp_q;
  logic                  out_mapped_q;
  status_e               out_status_q;

  logic [VA_W+VP_W-1:0]  vp_ext;
  logic [ADDR_W-1:0]     walk_addr;
  logic [ADDR_W-1:0]     waddr;
  logic [ENT_W-1:0]      wdata;
  logic [ENT_W-1:0]      entry;
  logic                  mem_we;
  logic                  frame_oor;
  logic                  no_frame;
  logic                  is_map;
  logic                  out_blocked;
  logic                  accept;
  logic                  step_down;

  // Decode walk state
  assign vp_ext      = {{VA_W{1'b0}}, req.virtual_page};
  assign walk_addr   = {frame_q[FRAME_W-1:0], vp_q[VA_W-1 -: INDEX_BITS]};
  assign frame_oor   = frame_q >= FR_W'(NUM_FRAMES);
  assign no_frame    = next_q >= NF_W'(NUM_FRAMES);
  assign entry       = rd_oor_q ? '0 : rdata_q;
  assign is_map      = (mode_q == MODE_MAP) || (mode_q == MODE_UNMAP);
  assign out_blocked = out_valid_q && !rsp.ready;
  assign accept      = ctrl_i.ready && req.valid;
  assign step_down   = (ctrl_i.act == ACT_DESCEND) || (ctrl_i.act == ACT_ALLOC);

  assign req.ready = ctrl_i.ready;

  // Report status to the sequencer
  assign flags_o.clr_busy    = clr_q != '1;
  assign flags_o.req_valid   = req.valid;
  assign flags_o.is_query    = !is_map;
  assign flags_o.is_unmap    = mode_q == MODE_UNMAP;
  assign flags_o.last        = level_q == LVL_W'(LEVELS - 1);
  assign flags_o.entry_zero  = entry == '0;
  assign flags_o.entry_valid = entry[0];
  assign flags_o.no_frame    = no_frame;
  assign flags_o.out_blocked = out_blocked;

  // Select memory write; drop writes into frames beyond the memory
  always_comb begin
    waddr  = walk_addr;
    wdata  = '0;
    mem_we = 1'b0;
    case (ctrl_i.act)
      ACT_CLEAR: begin
        waddr  = clr_q;
        mem_we = 1'b1;
      end
      ACT_ALLOC: begin
        wdata  = {PPN_BITS'(next_q), 1'b1};
        mem_we = !frame_oor;
      end
      ACT_MAP_WR: begin
        wdata  = {pp_q, 1'b1};
        mem_we = !frame_oor;
      end
      ACT_UNMAP_WR: begin
        wdata  = {entry[ENT_W-1:1], 1'b0};
        mem_we = !frame_oor;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[walk_addr];
    end
  end

  // Track whether the read addressed a frame beyond the memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_oor_q <= frame_oor;
    end
  end

  // Configuration registers and allocation counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      next_q <= NF_W'(1);
      clr_q  <= '0;
    end else begin
      if (ctrl_i.act == ACT_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cfg_we_i && (cfg_idx_i == CFG_ROOT_FRAME)) begin
        root_q <= cfg_data_i[ROOT_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_FIRST_FREE)) begin
        next_q <= NF_W'(cfg_data_i[FFREE_W-1:0]);
      end else if (ctrl_i.act == ACT_ALLOC) begin
        next_q <= next_q + NF_W'(1);
      end
    end
  end

  // Load a request and step the walk down one level
  always_ff @(posedge clk_i) begin
    if ((ctrl_i.act == ACT_LOAD) && accept) begin
      mode_q  <= req.mode;
      vp_q    <= vp_ext[VA_W-1:0];
      pp_q    <= req.physical_page[PPN_BITS-1:0];
      frame_q <= FR_W'(root_q);
      level_q <= '0;
    end else if (step_down) begin
      vp_q    <= vp_q << INDEX_BITS;
      level_q <= level_q + LVL_W'(1);
      if (ctrl_i.act == ACT_ALLOC) begin
        frame_q <= FR_W'(next_q);
      end else begin
        frame_q <= FR_W'(entry[ENT_W-1:1]);
      end
    end
  end

  // Hold the result of the finished walk
  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      ACT_MAP_WR, ACT_UNMAP_WR: begin
        res_pp_q     <= '0;
        res_mapped_q <= 1'b0;
        res_status_q <= ST_OK;
      end
      ACT_Q_MISS: begin
        res_pp_q     <= '0;
        res_mapped_q <= 1'b0;
        res_status_q <= ST_NO_MAPPING;
      end
      ACT_Q_HIT: begin
        res_pp_q     <= PP_W'(entry[ENT_W-1:1]);
        res_mapped_q <= 1'b1;
        res_status_q <= ST_OK;
      end
      ACT_NOFRAME: begin
        res_pp_q     <= '0;
        res_mapped_q <= 1'b0;
        res_status_q <= ST_NO_FRAMES;
      end
      default: begin
        res_pp_q <= res_pp_q;
      end
    endcase
  end

  // Output register: push when free, drop once the response is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.act == ACT_PUSH) && !out_blocked) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.act == ACT_PUSH) && !out_blocked) begin
      out_pp_q     <= res_pp_q;
      out_mapped_q <= res_mapped_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp.valid             = out_valid_q;
  assign rsp.physical_page_out = out_pp_q;
  assign rsp.mapped            = out_mapped_q;
  assign rsp.status            = out_status_q;

  // A frame is handed out only while the counter is below the frame count
  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_ALLOC) |-> !no_frame)
    else $error("frame allocated with counter exhausted");

  // The allocation counter only moves up unless reloaded
  a_next_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_we_i && (cfg_idx_i == CFG_FIRST_FREE)) |=> next_q >= $past(next_q))
    else $error("allocation counter went backwards");

  // A push into a free output register presents a result next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl_i.act == ACT_PUSH) && !out_blocked) |=> out_valid_q)
    else $error("pushed result not presented");

  // No new request is taken while the clearing pass runs
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_CLEAR) |-> !req.ready)
    else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

// File: rtl/multilevel_page_table_walker_unit.sv
// Top level: five-level radix page table walker with on-block frame memory.
// Requests: one at a time; the next is taken only once the previous result has entered the
//   output register, and that push waits while an earlier result has not drained.
// Reset: asynchronous; after reset a clearing pass zeroes the frame memory, one entry per cycle,
// before the first request is taken.
`default_nettype none

module multilevel_page_table_walker_unit
  import mptw_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned PPN_BITS   = PPN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mptw_req_if.sink                   req,
  mptw_rsp_if.source                 rsp
);

  ctrl_t      ctrl;
  seq_flags_t flags;

  // Sequence the walk from the control store
  mptw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Execute each step on the memory and walk registers
  mptw_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .LEVELS     (LEVELS),
    .INDEX_BITS (INDEX_BITS),
    .PPN_BITS   (PPN_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .flags_o    (flags),
    .req        (req),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// File: verif/tb_multilevel_page_table_walker_unit.sv
// Testbench for the page table walker: directed and random requests checked against a walk predictor.
`timescale 1ns / 100ps

module tb_multilevel_page_table_walker_unit;
  import mptw_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned FRAMES       = NUM_FRAMES_DEF;
  localparam int unsigned LVLS         = LEVELS_DEF;
  localparam int unsigned IDXW         = INDEX_BITS_DEF;
  localparam int unsigned FRAME_AW     = $clog2(FRAMES);
  localparam int unsigned MEM_ENTRIES  = FRAMES << IDXW;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 222;
  localparam int unsigned POOL_SIZE    = 16;

  // Mode code left unused by the package; the walker treats it as a query
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

  localparam logic [VP_W-1:0] VP_ALL = '1;
  localparam logic [PP_W-1:0] PP_ALL = '1;

  // Register settings per random phase, extremes included; the last phase draws its own
  localparam int unsigned PHASE_ROOT [NUM_PHASES] = '{0, 63, 0, 17, 63, 40, 5, 0};
  localparam int unsigned PHASE_FREE [NUM_PHASES] = '{1, 0, 64, 30, 60, 1, 12, 1};

  typedef logic [PP_W:0] pte_t;

  typedef struct packed {
    logic [PP_W-1:0] ppn;
    logic            mapped;
    status_e         status;
  } walk_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [MODE_W-1:0]     mode;
    logic [VP_W-1:0]       vp;
    logic [PP_W-1:0]       pp;
    bit                    fixed;
    walk_result_t          want;
    cfg_idx_e              sel;
    logic [CFG_DATA_W-1:0] val;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mptw_req_if req_if ();
  mptw_rsp_if rsp_if ();

  multilevel_page_table_walker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the walker state
  pte_t              frame_mem [MEM_ENTRIES];
  logic [ROOT_W-1:0] root_frame_q;
  int unsigned       next_free_frame;

  walk_result_t walk_result_q [$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  bit           hold_request;

  function automatic walk_result_t mk_res(logic [PP_W-1:0] ppn, logic mapped, status_e status);
    walk_result_t res;
    res.ppn    = ppn;
    res.mapped = mapped;
    res.status = status;
    return res;
  endfunction

  // Frames beyond the memory read as zero
  function automatic pte_t pte_read(logic [PP_W-1:0] frame, logic [IDXW-1:0] slot);
    if (frame >= FRAMES) return '0;
    return frame_mem[{frame[FRAME_AW-1:0], slot}];
  endfunction

  // Drop writes to frames beyond the memory
  function automatic void pte_write(logic [PP_W-1:0] frame, logic [IDXW-1:0] slot, pte_t pte);
    if (frame < FRAMES) frame_mem[{frame[FRAME_AW-1:0], slot}] = pte;
  endfunction

  // Walk the shadow table for one request and update it the way the walker would
  function automatic walk_result_t page_walk(logic [MODE_W-1:0] mode, logic [VP_W-1:0] vp,
                                             logic [PP_W-1:0] pp);
    walk_result_t    res;
    logic [PP_W-1:0] frame;
    pte_t            pte;
    logic [IDXW-1:0] slot;
    res   = mk_res('0, 1'b0, ST_OK);
    frame = PP_W'(root_frame_q);
    if (mode == MODE_MAP || mode == MODE_UNMAP) begin
      // Allocate a frame for every all-zero interior entry on the path
      for (int lvl = 0; lvl < LVLS - 1; lvl++) begin
        slot = vp[(LVLS - 1 - lvl) * IDXW +: IDXW];
        pte  = pte_read(frame, slot);
        if (pte == '0) begin
          if (next_free_frame >= FRAMES) begin
            res.status = ST_NO_FRAMES;
            return res;
          end
          pte = {PP_W'(next_free_frame), 1'b1};
          next_free_frame++;
          pte_write(frame, slot, pte);
        end
        frame = pte[PP_W:1];
      end
      slot = vp[IDXW-1:0];
      if (mode == MODE_MAP) begin
        pte_write(frame, slot, {pp, 1'b1});
      end else begin
        pte    = pte_read(frame, slot);
        pte[0] = 1'b0;
        pte_write(frame, slot, pte);
      end
      return res;
    end
    // Query: stop at the first invalid entry
    for (int lvl = 0; lvl < LVLS; lvl++) begin
      pte = pte_read(frame, vp[(LVLS - 1 - lvl) * IDXW +: IDXW]);
      if (!pte[0]) begin
        res.status = ST_NO_MAPPING;
        return res;
      end
      frame = pte[PP_W:1];
    end
    res.ppn    = frame;
    res.mapped = 1'b1;
    return res;
  endfunction

  function automatic row_t req_row(logic [MODE_W-1:0] mode, logic [VP_W-1:0] vp,
                                   logic [PP_W-1:0] pp);
    row_t row;
    row.kind  = ROW_REQ;
    row.mode  = mode;
    row.vp    = vp;
    row.pp    = pp;
    row.fixed = 1'b0;
    row.want  = mk_res('0, 1'b0, ST_OK);
    row.sel   = CFG_ROOT_FRAME;
    row.val   = '0;
    return row;
  endfunction

  function automatic row_t fixed_row(logic [MODE_W-1:0] mode, logic [VP_W-1:0] vp,
                                     logic [PP_W-1:0] pp, walk_result_t want);
    row_t row;
    row       = req_row(mode, vp, pp);
    row.fixed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e sel, logic [CFG_DATA_W-1:0] val);
    row_t row;
    row      = req_row(MODE_QUERY, '0, '0);
    row.kind = ROW_CFG;
    row.sel  = sel;
    row.val  = val;
    return row;
  endfunction

  // Offer one request, hold it until taken, then record what it should return
  task automatic send_walk(logic [MODE_W-1:0] mode, logic [VP_W-1:0] vp, logic [PP_W-1:0] pp,
                           bit use_fixed, walk_result_t fixed_res);
    walk_result_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= mode;
    req_if.virtual_page  <= vp;
    req_if.physical_page <= pp;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = page_walk(mode, vp, pp);
    walk_result_q.push_back(use_fixed ? fixed_res : pred);
  endtask

  // Drop valid, wait for every outstanding result, then let the walker settle
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (walk_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e sel, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_ROOT_FRAME) root_frame_q = val[ROOT_W-1:0];
    else next_free_frame = 32'(val);
  endtask

  // Response side: random stalls, plus a long hold-off on request
  initial begin : rsp_drive
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each response with the oldest predicted walk result
  always @(posedge clk_i) begin : rsp_check
    walk_result_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (walk_result_q.size() == 0) begin
        $error("response with no request outstanding");
        mismatch_cnt++;
      end else begin
        want = walk_result_q.pop_front();
        if (rsp_if.physical_page_out !== want.ppn) begin
          $error("physical_page_out: expected %h, got %h", want.ppn, rsp_if.physical_page_out);
          mismatch_cnt++;
        end
        if (rsp_if.mapped !== want.mapped) begin
          $error("mapped: expected %0d, got %0d", want.mapped, rsp_if.mapped);
          mismatch_cnt++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_multilevel_page_table_walker_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    row_t              dir_rows [$];
    logic [IDXW-1:0]   idx_opts [LVLS][2];
    logic [VP_W-1:0]   vp_pool [POOL_SIZE];
    logic [MODE_W-1:0] mode;
    logic [VP_W-1:0]   vp;
    logic [PP_W-1:0]   pp;
    int unsigned       r;
    int unsigned       root_sel;
    int unsigned       free_sel;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    req_if.valid         = 1'b0;
    req_if.mode          = '0;
    req_if.virtual_page  = '0;
    req_if.physical_page = '0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    hold_request         = 1'b0;
    mismatch_cnt         = 0;
    cycle_cnt            = 0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    root_frame_q    = '0;
    next_free_frame = 1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the clearing pass is over
    do @(posedge clk_i); while (req_if.ready !== 1'b1);

    // Empty table, reset registers
    dir_rows.push_back(fixed_row(MODE_QUERY, '0, '0, mk_res('0, 1'b0, ST_NO_MAPPING)));
    dir_rows.push_back(fixed_row(MODE_QUERY, VP_ALL, '0, mk_res('0, 1'b0, ST_NO_MAPPING)));
    dir_rows.push_back(fixed_row(MODE_RSVD, '0, PP_ALL, mk_res('0, 1'b0, ST_NO_MAPPING)));
    dir_rows.push_back(fixed_row(MODE_UNMAP, VP_ALL, PP_ALL, mk_res('0, 1'b0, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_MAP, '0, PP_ALL, mk_res('0, 1'b0, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_QUERY, '0, '0, mk_res(PP_ALL, 1'b1, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_MAP, VP_ALL, '0, mk_res('0, 1'b0, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_QUERY, VP_ALL, PP_ALL, mk_res('0, 1'b1, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_RSVD, VP_ALL, '0, mk_res('0, 1'b1, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_UNMAP, '0, '0, mk_res('0, 1'b0, ST_OK)));
    dir_rows.push_back(fixed_row(MODE_QUERY, '0, '0, mk_res('0, 1'b0, ST_NO_MAPPING)));
    // Remap over an unmapped leaf, alternating bit patterns
    dir_rows.push_back(req_row(MODE_MAP, '0, 52'h5_5555_5555_5555));
    dir_rows.push_back(req_row(MODE_QUERY, '0, '0));
    dir_rows.push_back(req_row(MODE_MAP, 45'h0AAA_AAAA_AAAA, 52'hA_AAAA_AAAA_AAAA));
    dir_rows.push_back(req_row(MODE_QUERY, 45'h0AAA_AAAA_AAAA, '0));
    dir_rows.push_back(req_row(MODE_QUERY, 45'd1, '0));
    // Allocation counter already exhausted
    dir_rows.push_back(cfg_row(CFG_FIRST_FREE, 7'd64));
    dir_rows.push_back(fixed_row(MODE_MAP, {9'd1, 36'd0}, PP_ALL,
                                 mk_res('0, 1'b0, ST_NO_FRAMES)));
    dir_rows.push_back(fixed_row(MODE_UNMAP, {9'd2, 36'd0}, '0,
                                 mk_res('0, 1'b0, ST_NO_FRAMES)));
    dir_rows.push_back(fixed_row(MODE_MAP, '0, 52'd123, mk_res('0, 1'b0, ST_OK)));
    // Counter runs out partway down; the partial path stays written
    dir_rows.push_back(cfg_row(CFG_FIRST_FREE, 7'd62));
    dir_rows.push_back(fixed_row(MODE_MAP, {9'd3, 36'd0}, 52'd5,
                                 mk_res('0, 1'b0, ST_NO_FRAMES)));
    dir_rows.push_back(req_row(MODE_QUERY, {9'd3, 36'd0}, '0));
    // Root in the last frame, handing out frame zero: tables alias each other
    dir_rows.push_back(cfg_row(CFG_ROOT_FRAME, 7'd63));
    dir_rows.push_back(cfg_row(CFG_FIRST_FREE, 7'd0));
    dir_rows.push_back(req_row(MODE_MAP, '0, 52'd77));
    dir_rows.push_back(req_row(MODE_QUERY, VP_ALL, '0));
    dir_rows.push_back(req_row(MODE_UNMAP, {9'd3, 36'd0}, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_rows[i].sel, dir_rows[i].val);
      end else begin
        send_walk(dir_rows[i].mode, dir_rows[i].vp, dir_rows[i].pp,
                  dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // Random phases: new register settings and a new page pool for each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      root_sel = (ph == NUM_PHASES - 1) ? $urandom_range(63) : PHASE_ROOT[ph];
      free_sel = (ph == NUM_PHASES - 1) ? $urandom_range(64) : PHASE_FREE[ph];
      cfg_write(CFG_ROOT_FRAME, CFG_DATA_W'(root_sel));
      cfg_write(CFG_FIRST_FREE, CFG_DATA_W'(free_sel));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase

      // Pages share index choices per level, so walks overlap and hit
      foreach (idx_opts[l, c]) begin
        r = $urandom_range(9);
        idx_opts[l][c] = (r == 0) ? '0 : (r == 1) ? '1 : IDXW'($urandom_range(511));
      end
      foreach (vp_pool[p]) begin
        for (int l = 0; l < LVLS; l++)
          vp_pool[p][(LVLS - 1 - l) * IDXW +: IDXW] = idx_opts[l][$urandom_range(1)];
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the response side off so the walker backs up into its input
        if (ph == 0 && n == 20) hold_request = 1'b1;
        // Pause the sender until every result has come
        if (ph == 5 && n == 110) wait_drained();
        r    = $urandom_range(99);
        mode = (r < 40) ? MODE_QUERY : (r < 72) ? MODE_MAP : (r < 92) ? MODE_UNMAP : MODE_RSVD;
        vp   = ($urandom_range(99) < 82) ? vp_pool[$urandom_range(POOL_SIZE - 1)]
                                         : VP_W'({$urandom(), $urandom()});
        r    = $urandom_range(99);
        pp   = (r < 5) ? '0 : (r < 10) ? PP_ALL : PP_W'({$urandom(), $urandom()});
        send_walk(mode, vp, pp, 1'b0, mk_res('0, 1'b0, ST_OK));
      end
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("tb_multilevel_page_table_walker_unit: done, clean");
    end else begin
      $display("tb_multilevel_page_table_walker_unit: done, errors");
    end
    $finish;
  end

endmodule
